// ===== sv/stnh_pkg.sv =====
// shared types, widths and codes of the segment / triangle nearest hit unit
// no dependencies; used by stnh_mac, stnh_div and the top level
package stnh_pkg;

	localparam int COORD_W = 32;              // Q16.16 coordinate
	localparam int HALF_W  = 18;              // multiplier operand split
	localparam int A_W     = 52;              // wide multiplier operand
	localparam int B_W     = 2 * HALF_W;      // narrow multiplier operand
	localparam int PART_W  = A_W + HALF_W;    // product with the upper half
	localparam int PROD_W  = PART_W + HALF_W; // full product
	localparam int ACC_W   = PROD_W + 2;      // sum of three products
	localparam int D_W     = 68;              // plane distances
	localparam int Q_W     = 17;              // Q1.16 fraction incl. 1.0
	localparam int FRAC_SH = 16;
	localparam int P_W     = COORD_W + 2;     // crossing point
	localparam int EN_W    = A_W;             // edge normal
	localparam int ACT_W   = 3;

	localparam logic [Q_W-1:0] FRAC_ONE = Q_W'(1) << FRAC_SH;

	localparam logic [ACT_W-1:0] ACT_SEG_START = 3'd0;
	localparam logic [ACT_W-1:0] ACT_SEG_END   = 3'd1;
	localparam logic [ACT_W-1:0] ACT_VERT0     = 3'd2;
	localparam logic [ACT_W-1:0] ACT_VERT1     = 3'd3;
	localparam logic [ACT_W-1:0] ACT_VERT2     = 3'd4;
	localparam logic [ACT_W-1:0] ACT_NORMAL    = 3'd5;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef coord_t [2:0] vec_t;

	typedef struct packed {
		logic mul_hi;
		logic mul_lo;
		logic acc_en;
		logic acc_load;
		logic acc_sub;
	} mac_ctl_t;

	function automatic logic [1:0] nxt3(input logic [1:0] i);
		return (i == 2'd2) ? 2'd0 : i + 2'd1;
	endfunction

endpackage

// ===== sv/stnh_mac.sv =====
// shared multiply-accumulate unit: two half products per multiply, then accumulate
// depends on stnh_pkg
module stnh_mac (
	input  logic                                clk,
	input  stnh_pkg::mac_ctl_t                  ctl,
	input  logic signed [stnh_pkg::A_W-1:0]     a,
	input  logic signed [stnh_pkg::B_W-1:0]     b,
	output logic signed [stnh_pkg::ACC_W-1:0]   acc
);
	logic signed [stnh_pkg::HALF_W-1:0]   b_hi;
	logic signed [stnh_pkg::HALF_W:0]     b_lo;
	logic signed [stnh_pkg::PART_W-1:0]   part_q;
	logic signed [stnh_pkg::PROD_W-1:0]   lo_prod;
	logic signed [stnh_pkg::PROD_W-1:0]   prod_q;
	logic signed [stnh_pkg::ACC_W-1:0]    prod_ext;
	logic signed [stnh_pkg::ACC_W-1:0]    base;
	logic signed [stnh_pkg::ACC_W-1:0]    acc_q;

	assign b_hi     = b[stnh_pkg::B_W-1:stnh_pkg::HALF_W];
	assign b_lo     = {1'b0, b[stnh_pkg::HALF_W-1:0]};
	assign lo_prod  = a * b_lo;
	assign prod_ext = {{(stnh_pkg::ACC_W-stnh_pkg::PROD_W){prod_q[stnh_pkg::PROD_W-1]}}, prod_q};
	assign base     = ctl.acc_load ? '0 : acc_q;

	always_ff @(posedge clk) begin
		if (ctl.mul_hi) begin
			part_q <= a * b_hi;
		end
		if (ctl.mul_lo) begin
			prod_q <= {part_q, {stnh_pkg::HALF_W{1'b0}}} + lo_prod;
		end
		if (ctl.acc_en) begin
			acc_q <= ctl.acc_sub ? base - prod_ext : base + prod_ext;
		end
	end

	assign acc = acc_q;
endmodule

// ===== sv/stnh_div.sv =====
// restoring divider for the crossing fraction, one quotient bit per cycle
// depends on stnh_pkg
module stnh_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [stnh_pkg::D_W-1:0]     num,
	input  logic [stnh_pkg::D_W-1:0]     den,
	output logic                         done,
	output logic [stnh_pkg::Q_W-1:0]     quot
);
	localparam int R_W = stnh_pkg::D_W + stnh_pkg::FRAC_SH;
	localparam int C_W = $clog2(stnh_pkg::Q_W);

	logic [R_W-1:0]           rem_q;
	logic [R_W-1:0]           dv_q;
	logic [stnh_pkg::Q_W-1:0] quot_q;
	logic [C_W-1:0]           cnt_q;
	logic                     busy_q;
	logic                     done_q;
	logic                     ge;

	assign ge = rem_q >= dv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == C_W'(stnh_pkg::Q_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= {num, {stnh_pkg::FRAC_SH{1'b0}}};
			dv_q   <= {den, {stnh_pkg::FRAC_SH{1'b0}}};
			quot_q <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - dv_q;
			end
			quot_q <= {quot_q[stnh_pkg::Q_W-2:0], ge};
			dv_q   <= dv_q >> 1;
		end
	end

	assign done = done_q;
	assign quot = quot_q;
endmodule

// ===== sv/segment_triangle_nearest_hit_unit.sv =====
// top level: item capture, test sequencer, nearest hit tracking and result register
// depends on stnh_pkg, stnh_mac, stnh_div
//
// channel  dir  tdata                          tuser      tlast
// s_*      in   coord_x, coord_y, coord_z      action     last_triangle
// m_*      out  fraction (17b, zero padded)    hit        -
//
// segment, vertex and unused items are captured without leaving the idle state.
// a normal item keeps s_tready low after its accept: every dot and cross product goes
// through one shared multiply-accumulate unit (high half, low half, accumulate
// per term, write back per sum); the fraction goes through a 17 step restoring
// divider, skipped by a crossing without division; a plane miss ends after both distances.
// s_tready is high only while the sequencer is idle; a final item also waits while
// the previous result item is still held on m_*.
// reset clears segment, nearest hit and control; vertices are undefined until loaded.
module segment_triangle_nearest_hit_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,   // coord_x, coord_y, coord_z
	input  logic [2:0]  s_tuser,   // action
	input  logic        s_tlast,   // last_triangle
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // fraction
	output logic        m_tuser    // hit
);
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_D1   = 4'd1;
	localparam logic [3:0] S_D2   = 4'd2;
	localparam logic [3:0] S_CHK  = 4'd3;
	localparam logic [3:0] S_DEN  = 4'd4;
	localparam logic [3:0] S_DIV  = 4'd5;
	localparam logic [3:0] S_P    = 4'd6;
	localparam logic [3:0] S_EN   = 4'd7;
	localparam logic [3:0] S_DOT  = 4'd8;
	localparam logic [3:0] S_UPD  = 4'd9;

	localparam int CW = stnh_pkg::COORD_W;
	localparam int DW = stnh_pkg::D_W;
	localparam int QW = stnh_pkg::Q_W;
	localparam int SH = stnh_pkg::FRAC_SH;

	logic [3:0]            state_q;
	logic [1:0]            ph_q, t_q, c_q, edge_q;
	logic [1:0]            t_last;
	stnh_pkg::vec_t        s_q, segend_q, n_q, cin;
	stnh_pkg::vec_t        v_q [3];
	stnh_pkg::vec_t        tv_q [3];
	logic signed [stnh_pkg::P_W-1:0]  p_q [3];
	logic signed [stnh_pkg::EN_W-1:0] en_q [3];
	logic signed [DW-1:0]  d1_q, d2_q, den_q;
	logic [DW-1:0]         num_mag, den_mag;
	logic [QW-1:0]         k_q, best_q, quot;
	logic                  any_q, last_q, found_q;
	logic                  out_valid_q, out_hit_q;
	logic [QW-1:0]         out_frac_q;
	logic                  in_acc, div_start, div_done;
	stnh_pkg::mac_ctl_t    mac_ctl;
	logic signed [stnh_pkg::A_W-1:0]   op_a;
	logic signed [stnh_pkg::B_W-1:0]   op_b;
	logic signed [stnh_pkg::ACC_W-1:0] acc;
	logic [1:0]            ia, ib;
	logic signed [CW:0]    diff_a;
	logic signed [stnh_pkg::P_W:0] w_t;
	logic signed [stnh_pkg::P_W-1:0] p_new;
	logic                  mac_st, d1_pos, d1_neg, d2_pos, d2_neg;
	logic                  upd, new_any, out_load;
	logic [QW-1:0]         new_best;

	assign cin[0] = s_tdata[31:0];
	assign cin[1] = s_tdata[63:32];
	assign cin[2] = s_tdata[95:64];

	assign s_tready = (state_q == S_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_hit_q;
	assign m_tdata  = {{(24-QW){1'b0}}, out_frac_q};

	assign mac_st = (state_q inside {S_D1, S_D2, S_P, S_EN, S_DOT});

	always_comb begin
		case (state_q)
			S_P:     t_last = 2'd0;
			S_EN:    t_last = 2'd1;
			default: t_last = 2'd2;
		endcase
	end

	// cross product term indexes: first term ed[c+1]*n[c+2], second ed[c+2]*n[c+1]
	assign ia = (t_q == 2'd0) ? stnh_pkg::nxt3(c_q) : stnh_pkg::nxt3(stnh_pkg::nxt3(c_q));
	assign ib = (t_q == 2'd0) ? stnh_pkg::nxt3(stnh_pkg::nxt3(c_q)) : stnh_pkg::nxt3(c_q);

	always_comb begin
		diff_a = '0;
		op_a   = '0;
		op_b   = '0;
		w_t    = '0;
		case (state_q)
			S_D1: begin
				diff_a = {s_q[t_q][CW-1], s_q[t_q]} - {v_q[0][t_q][CW-1], v_q[0][t_q]};
				op_a   = stnh_pkg::A_W'(diff_a);
				op_b   = stnh_pkg::B_W'(n_q[t_q]);
			end
			S_D2: begin
				diff_a = {segend_q[t_q][CW-1], segend_q[t_q]}
					- {v_q[0][t_q][CW-1], v_q[0][t_q]};
				op_a   = stnh_pkg::A_W'(diff_a);
				op_b   = stnh_pkg::B_W'(n_q[t_q]);
			end
			S_P: begin
				diff_a = {segend_q[c_q][CW-1], segend_q[c_q]} - {s_q[c_q][CW-1], s_q[c_q]};
				op_a   = stnh_pkg::A_W'(diff_a);
				op_b   = stnh_pkg::B_W'(k_q);
			end
			S_EN: begin
				diff_a = {tv_q[1][ia][CW-1], tv_q[1][ia]} - {tv_q[0][ia][CW-1], tv_q[0][ia]};
				op_a   = stnh_pkg::A_W'(diff_a);
				op_b   = stnh_pkg::B_W'(n_q[ib]);
			end
			S_DOT: begin
				w_t  = {p_q[t_q][stnh_pkg::P_W-1], p_q[t_q]}
					- (stnh_pkg::P_W+1)'(tv_q[0][t_q]);
				op_a = en_q[t_q];
				op_b = stnh_pkg::B_W'(w_t);
			end
			default: begin
				op_a = '0;
			end
		endcase
	end

	always_comb begin
		mac_ctl          = '0;
		mac_ctl.mul_hi   = mac_st && (ph_q == 2'd0);
		mac_ctl.mul_lo   = mac_st && (ph_q == 2'd1);
		mac_ctl.acc_en   = mac_st && (ph_q == 2'd2);
		mac_ctl.acc_load = (t_q == 2'd0);
		mac_ctl.acc_sub  = (state_q == S_EN) && (t_q == 2'd1);
	end

	stnh_mac u_mac (
		.clk (clk),
		.ctl (mac_ctl),
		.a   (op_a),
		.b   (op_b),
		.acc (acc)
	);

	assign num_mag   = d1_q[DW-1] ? DW'(-d1_q) : d1_q;
	assign den_mag   = den_q[DW-1] ? DW'(-den_q) : den_q;
	assign div_start = (state_q == S_DEN) && (den_q != '0) && (d1_q != '0)
		&& (d1_q[DW-1] == den_q[DW-1]);

	stnh_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_mag),
		.den    (den_mag),
		.done   (div_done),
		.quot   (quot)
	);

	assign d1_pos = !d1_q[DW-1] && (d1_q != '0);
	assign d1_neg = d1_q[DW-1];
	assign d2_pos = !d2_q[DW-1] && (d2_q != '0);
	assign d2_neg = d2_q[DW-1];

	assign p_new = stnh_pkg::P_W'(s_q[c_q]) + acc[stnh_pkg::P_W+SH-1:SH];

	assign upd      = found_q && (!any_q || (k_q < best_q));
	assign new_any  = any_q || found_q;
	assign new_best = upd ? k_q : best_q;
	assign out_load = (state_q == S_UPD) && last_q && (!out_valid_q || m_tready);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ph_q        <= '0;
			t_q         <= '0;
			c_q         <= '0;
			edge_q      <= '0;
			any_q       <= 1'b0;
			best_q      <= '0;
			out_valid_q <= 1'b0;
			s_q         <= '0;
			segend_q    <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tvalid && m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (mac_st) begin
				if (ph_q == 2'd2) begin
					if (t_q == t_last) begin
						ph_q <= 2'd3;
					end else begin
						ph_q <= 2'd0;
						t_q  <= t_q + 2'd1;
					end
				end else if (ph_q == 2'd3) begin
					ph_q <= 2'd0;
					t_q  <= 2'd0;
				end else begin
					ph_q <= ph_q + 2'd1;
				end
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						case (s_tuser)
							stnh_pkg::ACT_SEG_START: begin
								s_q    <= cin;
								any_q  <= 1'b0;
								best_q <= '0;
							end
							stnh_pkg::ACT_SEG_END: segend_q <= cin;
							stnh_pkg::ACT_NORMAL: begin
								state_q <= S_D1;
								ph_q    <= '0;
								t_q     <= '0;
							end
							default: ;
						endcase
					end
				end
				S_D1: if (ph_q == 2'd3) state_q <= S_D2;
				S_D2: if (ph_q == 2'd3) state_q <= S_CHK;
				S_CHK: begin
					if ((d1_pos && d2_pos) || (d1_neg && d2_neg)) begin
						state_q <= S_UPD;
					end else begin
						state_q <= S_DEN;
					end
				end
				S_DEN: begin
					state_q <= div_start ? S_DIV : S_P;
					c_q     <= '0;
				end
				S_DIV: if (div_done) state_q <= S_P;
				S_P: begin
					if (ph_q == 2'd3) begin
						if (c_q == 2'd2) begin
							state_q <= S_EN;
							c_q     <= '0;
							edge_q  <= '0;
						end else begin
							c_q <= c_q + 2'd1;
						end
					end
				end
				S_EN: begin
					if (ph_q == 2'd3) begin
						if (c_q == 2'd2) begin
							state_q <= S_DOT;
							c_q     <= '0;
						end else begin
							c_q <= c_q + 2'd1;
						end
					end
				end
				S_DOT: begin
					if (ph_q == 2'd3) begin
						// positive side of any edge plane is a miss
						if ((!acc[stnh_pkg::ACC_W-1] && (acc != '0)) || (edge_q == 2'd2)) begin
							state_q <= S_UPD;
						end else begin
							state_q <= S_EN;
							edge_q  <= edge_q + 2'd1;
						end
					end
				end
				S_UPD: begin
					if (!last_q || !out_valid_q || m_tready) begin
						any_q   <= new_any;
						best_q  <= new_best;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			case (s_tuser)
				stnh_pkg::ACT_VERT0: v_q[0] <= cin;
				stnh_pkg::ACT_VERT1: v_q[1] <= cin;
				stnh_pkg::ACT_VERT2: v_q[2] <= cin;
				stnh_pkg::ACT_NORMAL: begin
					n_q     <= cin;
					last_q  <= s_tlast;
					found_q <= 1'b0;
				end
				default: ;
			endcase
		end
		if (state_q == S_D1 && ph_q == 2'd3) d1_q <= acc[DW-1:0];
		if (state_q == S_D2 && ph_q == 2'd3) d2_q <= acc[DW-1:0];
		if (state_q == S_CHK) den_q <= d1_q - d2_q;
		if (state_q == S_DEN) k_q <= '0;
		if (state_q == S_DIV && div_done) begin
			k_q <= (quot > stnh_pkg::FRAC_ONE) ? stnh_pkg::FRAC_ONE : quot;
		end
		if (state_q == S_P && ph_q == 2'd3) begin
			p_q[c_q] <= p_new;
			if (c_q == 2'd2) tv_q <= v_q;
		end
		if (state_q == S_EN && ph_q == 2'd3) begin
			en_q[c_q] <= acc[stnh_pkg::EN_W+SH-1:SH];
		end
		if (state_q == S_DOT && ph_q == 2'd3) begin
			if (!(!acc[stnh_pkg::ACC_W-1] && (acc != '0))) begin
				if (edge_q == 2'd2) begin
					found_q <= 1'b1;
				end else begin
					// next edge starts at the following vertex
					tv_q[0] <= tv_q[1];
					tv_q[1] <= tv_q[2];
					tv_q[2] <= tv_q[0];
				end
			end
		end
		if (out_load) begin
			out_hit_q  <= new_any;
			out_frac_q <= new_any ? new_best : '0;
		end
	end
endmodule
